// ===== design/pmnc_pkg.sv =====
// Package for the payload magic-number classifier.
// Holds the class codes, the signature table and the match result type.
// No dependencies.
`default_nettype none

package pmnc_pkg;

  localparam int unsigned CLASS_W    = 5;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned SIG_COUNT  = 34;
  localparam int unsigned MIN_LENGTH = 4;

  typedef logic [CLASS_W-1:0] class_t;

  localparam class_t CLS_STILL_UNKNOWN = 5'd0;
  localparam class_t CLS_UNKNOWN       = 5'd1;
  localparam class_t CLS_AVI           = 5'd2;
  localparam class_t CLS_EXE           = 5'd3;
  localparam class_t CLS_OGG           = 5'd4;
  localparam class_t CLS_ZIP           = 5'd5;
  localparam class_t CLS_MPEG          = 5'd6;
  localparam class_t CLS_RAR           = 5'd7;
  localparam class_t CLS_EBML          = 5'd8;
  localparam class_t CLS_JPG           = 5'd9;
  localparam class_t CLS_GIF           = 5'd10;
  localparam class_t CLS_PHP           = 5'd11;
  localparam class_t CLS_SCRIPT        = 5'd12;
  localparam class_t CLS_PDF           = 5'd13;
  localparam class_t CLS_PNG           = 5'd14;
  localparam class_t CLS_HTML          = 5'd15;
  localparam class_t CLS_7ZIP          = 5'd16;
  localparam class_t CLS_GZIP          = 5'd17;
  localparam class_t CLS_XML           = 5'd18;
  localparam class_t CLS_FLAC          = 5'd19;
  localparam class_t CLS_MP3           = 5'd20;
  localparam class_t CLS_RPM           = 5'd21;
  localparam class_t CLS_WZ            = 5'd22;
  localparam class_t CLS_FLV           = 5'd23;
  localparam class_t CLS_BKF           = 5'd24;
  localparam class_t CLS_DOC           = 5'd25;
  localparam class_t CLS_ASP           = 5'd26;
  localparam class_t CLS_WMS           = 5'd27;
  localparam class_t CLS_DEB           = 5'd28;
  localparam class_t CLS_SPF           = 5'd29;
  localparam class_t CLS_ABIF          = 5'd30;
  localparam class_t CLS_BZIP2         = 5'd31;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd20;

  typedef struct packed {
    logic [31:0] pattern;
    logic [31:0] mask;
    class_t      code;
  } sig_t;

  typedef struct packed {
    logic   hit;
    class_t code;
  } match_t;

  // bytes packed first byte in the top octet; earlier entries win
  localparam sig_t SIG_TABLE [SIG_COUNT] = '{
    '{32'h52494646, 32'hFFFFFFFF, CLS_AVI},    // RIFF
    '{32'h4D5A0000, 32'hFFFF00FF, CLS_EXE},    // MZ, third byte free
    '{32'h4F676753, 32'hFFFFFFFF, CLS_OGG},    // OggS
    '{32'h504B0304, 32'hFFFFFFFF, CLS_ZIP},
    '{32'h000001BA, 32'hFFFFFFFF, CLS_MPEG},
    '{32'h52617221, 32'hFFFFFFFF, CLS_RAR},    // Rar!
    '{32'h1A45DFA3, 32'hFFFFFFFF, CLS_EBML},
    '{32'hFFD80000, 32'hFFFF0000, CLS_JPG},
    '{32'h47494638, 32'hFFFFFFFF, CLS_GIF},
    '{32'h3C3F7068, 32'hFFFFFFFF, CLS_PHP},
    '{32'h23212F62, 32'hFFFFFFFF, CLS_SCRIPT},
    '{32'h25504446, 32'hFFFFFFFF, CLS_PDF},
    '{32'h89504E47, 32'hFFFFFFFF, CLS_PNG},
    '{32'h3C68746D, 32'hFFFFFFFF, CLS_HTML},
    '{32'h0A3C2144, 32'hFFFFFFFF, CLS_HTML},
    '{32'h377ABCAF, 32'hFFFFFFFF, CLS_7ZIP},
    '{32'h1F8B0800, 32'hFFFFFF00, CLS_GZIP},
    '{32'h3C21444F, 32'hFFFFFFFF, CLS_XML},
    '{32'h664C6143, 32'hFFFFFFFF, CLS_FLAC},
    '{32'h49443303, 32'hFFFFFFFF, CLS_MP3},
    '{32'hFFFB90C0, 32'hFFFFFFFF, CLS_MP3},
    '{32'hEDABEEDB, 32'hFFFFFFFF, CLS_RPM},
    '{32'h577A5061, 32'hFFFFFFFF, CLS_WZ},
    '{32'h464C5601, 32'hFFFFFFFF, CLS_FLV},
    '{32'h54415045, 32'hFFFFFFFF, CLS_BKF},
    '{32'hD0CF11E0, 32'hFFFFFFFF, CLS_DOC},
    '{32'h3C254020, 32'hFFFFFFFF, CLS_ASP},
    '{32'h3C212D2D, 32'hFFFFFFFF, CLS_WMS},
    '{32'h213C6172, 32'hFFFFFFFF, CLS_DEB},
    '{32'h3C3F786D, 32'hFFFFFFFF, CLS_XML},
    '{32'h3C697120, 32'hFFFFFFFF, CLS_XML},
    '{32'h53504649, 32'hFFFFFFFF, CLS_SPF},
    '{32'h41424946, 32'hFFFFFFFF, CLS_ABIF},
    '{32'h425A6839, 32'hFFFFFFFF, CLS_BZIP2}
  };

endpackage

`default_nettype wire

// ===== design/pmnc_match.sv =====
// Signature matcher: compares a four-byte word with every table entry in
// parallel and picks the earliest hit. Combinational. Uses pmnc_pkg.
`default_nettype none

module pmnc_match (
  input  logic [31:0]      word,
  output pmnc_pkg::match_t match
);
  import pmnc_pkg::*;

  logic [SIG_COUNT-1:0] hits;

  always_comb begin
    for (int i = 0; i < SIG_COUNT; i++) begin
      hits[i] = ((word & SIG_TABLE[i].mask) == SIG_TABLE[i].pattern);
    end
  end

  // walk from lowest priority up so the first entry in the table wins
  always_comb begin
    match.hit  = |hits;
    match.code = CLS_STILL_UNKNOWN;
    for (int i = SIG_COUNT - 1; i >= 0; i--) begin
      if (hits[i]) begin
        match.code = SIG_TABLE[i].code;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/payload_magic_number_classifier.sv =====
// Top level of the payload magic-number classifier: input register,
// signature match and give-up rule, result register. Uses pmnc_pkg, pmnc_match.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  command   | start, busy            | first..fourth_byte, payload_length,
//            |                        | flow_packet_count, current_class
//  result    | done (one-cycle strobe)| new_class, class_written
//  config    | cfg_valid, cfg_ready   | cfg_data (give-up packet limit)
//
// One item per cycle; busy stays low, so a command is taken on every start.
// The result passes through the input register, then the matcher and
// give-up compare feed the result register.
// Synchronous reset clears the pipeline valids and sets the limit to 20.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module payload_magic_number_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    first_byte,
  input  logic [7:0]                    second_byte,
  input  logic [7:0]                    third_byte,
  input  logic [7:0]                    fourth_byte,
  input  logic [pmnc_pkg::LEN_W-1:0]    payload_length,
  input  logic [pmnc_pkg::LIMIT_W-1:0]  flow_packet_count,
  input  logic [pmnc_pkg::CLASS_W-1:0]  current_class,
  output logic                          done,
  output logic [pmnc_pkg::CLASS_W-1:0]  new_class,
  output logic                          class_written,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmnc_pkg::LIMIT_W-1:0]  cfg_data
);
  import pmnc_pkg::*;

  logic [LIMIT_W-1:0] limit;

  logic               in_valid;
  logic [31:0]        in_word;
  logic               in_long;
  logic [LIMIT_W-1:0] in_count;
  class_t             in_class;

  match_t             match;
  logic               give_up;
  class_t             class_next;
  logic               written_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word  <= {first_byte, second_byte, third_byte, fourth_byte};
      in_long  <= (payload_length >= LEN_W'(MIN_LENGTH));
      in_count <= flow_packet_count;
      in_class <= current_class;
    end
  end

  pmnc_match u_match (
    .word  (in_word),
    .match (match)
  );

  assign give_up = (in_class == CLS_STILL_UNKNOWN) && (in_count > limit);

  always_comb begin
    class_next   = in_class;
    written_next = 1'b0;
    if (in_long) begin
      if (match.hit) begin
        class_next   = match.code;
        written_next = 1'b1;
      end else if (give_up) begin
        class_next   = CLS_UNKNOWN;
        written_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      new_class     <= class_next;
      class_written <= written_next;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing two cycles after command");

  a_unchanged: assert property (@(posedge clk) disable iff (rst)
    (done && !class_written) |-> (new_class == $past(current_class, 2)))
    else $error("class changed without a write");

  a_short: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(payload_length, 2) < LEN_W'(MIN_LENGTH))) |-> !class_written)
    else $error("short payload produced a class write");

  a_give_up: assert property (@(posedge clk) disable iff (rst)
    (done && class_written && (new_class == CLS_UNKNOWN))
      |-> ($past(current_class, 2) == CLS_STILL_UNKNOWN)
       && ($past(flow_packet_count, 2) > limit))
    else $error("give-up fired without its conditions");
`endif

endmodule

`default_nettype wire
